FILE: rtl/core/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial-division prime test
// Holds the controller state type, the command and status bundles that join
// the controller to the datapath, and the fixed constants of the algorithm.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  // First odd trial divisor and its square
  localparam int unsigned FIRST_DIV    = 3;
  localparam int unsigned FIRST_SQ     = 9;
  // Step between odd divisors, and the constant term of (d+2)^2 - d^2 = 4d + 4
  localparam int unsigned DIV_STEP     = 2;
  localparam int unsigned SQ_STEP_K    = 4;
  // Result channel payload width (one flag bit padded to a byte)
  localparam int unsigned OUT_TDATA_W  = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_BOUND,
    ST_DIV,
    ST_CHECK_REM,
    ST_PUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch candidate, reset divisor and square
    logic div_start;  // clear remainder unit
    logic div_step;   // one restoring-division bit
    logic advance;    // move to next odd divisor
    logic out_load;   // load result register
    logic flag;       // value for result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trivial;      // decided without trial division
    logic trivial_flag; // verdict for the trivial case
    logic bound_over;   // divisor squared exceeds candidate
    logic div_done;     // current step is the last remainder bit
    logic rem_zero;     // remainder is zero
    logic out_busy;     // result register full and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl: sequencing state machine of the prime test
// Walks each candidate through classification, the divisor bound check, the
// bit-serial remainder and the result push, driving the datapath by commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire tdpt_pkg::sts_t sts,
  output tdpt_pkg::cmd_t     cmd
);

  import tdpt_pkg::*;

  state_t state_r, state_nxt;
  logic   verdict_r, verdict_nxt;

  // State and verdict registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      verdict_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      verdict_r <= verdict_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (sts.trivial) begin
          verdict_nxt = sts.trivial_flag;
          state_nxt   = ST_PUSH;
        end else begin
          state_nxt   = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (sts.bound_over) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_PUSH;
        end else begin
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_CHECK_REM;
      end
      ST_CHECK_REM: begin
        if (sts.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_PUSH;
        end else begin
          state_nxt   = ST_BOUND;
        end
      end
      ST_PUSH: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.flag      = verdict_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CLASSIFY: ;
      ST_BOUND: begin
        cmd.div_start = !sts.bound_over;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_CHECK_REM: begin
        cmd.advance = !sts.rem_zero;
      end
      ST_PUSH: begin
        cmd.out_load = !sts.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// tdpt_dpath: datapath of the prime test
// Holds the candidate, the odd trial divisor and its running square, a
// restoring bit-serial remainder unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_dpath #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [DATA_WIDTH-1:0]   cand,
  input  wire tdpt_pkg::cmd_t          cmd,
  output tdpt_pkg::sts_t               sts,
  output logic                         out_valid,
  output logic                         out_flag,
  input  wire logic                    out_ready
);

  import tdpt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] v_r;
  logic [DATA_WIDTH-1:0] d_r, d_nxt;
  logic [DATA_WIDTH:0]   sq_r, sq_nxt;
  logic [DATA_WIDTH-1:0] sh_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  logic                  out_flag_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   trial_sub;

  // Next divisor and its square: (d+2)^2 = d^2 + 4d + 4
  assign d_nxt  = d_r + DATA_WIDTH'(DIV_STEP);
  assign sq_nxt = sq_r + ({1'b0, d_r} << 2) + (DATA_WIDTH+1)'(SQ_STEP_K);

  // Restoring remainder step: shift in next candidate bit, subtract if it fits
  assign trial     = {rem_r, sh_r[DATA_WIDTH-1]};
  assign trial_sub = trial - {1'b0, d_r};
  always_comb begin
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = trial_sub[DATA_WIDTH-1:0];
    end else begin
      rem_nxt = trial[DATA_WIDTH-1:0];
    end
  end

  // Candidate, divisor and square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r  <= cand;
      d_r  <= DATA_WIDTH'(FIRST_DIV);
      sq_r <= (DATA_WIDTH+1)'(FIRST_SQ);
    end else if (cmd.advance) begin
      d_r  <= d_nxt;
      sq_r <= sq_nxt;
    end
  end

  // Remainder unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      sh_r  <= v_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[DATA_WIDTH-2:0], 1'b0};
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_flag_r <= cmd.flag;
  end

  assign out_valid = out_valid_r;
  assign out_flag  = out_flag_r;

  // Status: negatives, 0 to 3 and evens are decided at once; 2 and 3 are prime
  always_comb begin
    sts.trivial      = v_r[DATA_WIDTH-1] || (v_r[DATA_WIDTH-1:2] == '0) || !v_r[0];
    sts.trivial_flag = !v_r[DATA_WIDTH-1] && (v_r[DATA_WIDTH-1:2] == '0) && v_r[1];
    sts.bound_over   = sq_r > {1'b0, v_r};
    sts.div_done     = cnt_r == CNT_W'(DATA_WIDTH - 1);
    sts.rem_zero     = rem_r == '0;
    sts.out_busy     = out_valid_r && !out_ready;
  end

endmodule

`default_nettype wire

FILE: rtl/core/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test of a signed integer
// Top level joining the sequencing controller and the trial-division datapath.
// ----------------------------------------------------------------------------
// Each accepted candidate yields one result transaction whose flag is 1 when
// the candidate is prime. Negative values, 0, 1, 2, 3 and even values are
// decided at once: after acceptance the block classifies the candidate and
// then pushes the result, without trial division. An odd candidate is tested
// against 3, 5, 7, ... while the divisor squared does not exceed it; each
// divisor takes a bound check, a full pass of the bit-serial remainder unit
// that retires one candidate bit per cycle, and a remainder check. A prime
// near 2^(DATA_WIDTH-1) needs about sqrt(2^(DATA_WIDTH-1))/2 divisors, roughly
// 23170 at DATA_WIDTH = 32. One candidate is processed at a time; the next is
// accepted once the previous result sits in the output register, even if not
// yet taken.
`default_nettype none

module trial_division_prime_test #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // in_tdata: [DATA_WIDTH-1:0] candidate, zero padded to whole bytes
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]          in_tdata,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // out_tdata: [0] prime_flag, [7:1] zero
  output logic [tdpt_pkg::OUT_TDATA_W-1:0]               out_tdata,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready
);

  import tdpt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_flag;

  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tdpt_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cand      (in_tdata[DATA_WIDTH-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_flag  (out_flag),
    .out_ready (out_tready)
  );

  // Pack the flag into the low bit
  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_flag};

  // An accepted candidate occupies the block for at least the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a candidate is in flight");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result register overwritten");

  // Remainder work starts only for a divisor within the bound
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.bound_over)
    else $error("division started past the square-root bound");

endmodule

`default_nettype wire
